@@ hw/rtl/wst_pkg.sv @@
`timescale 1ns / 1ps
package wst_pkg;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_SELECT = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_FILL   = 2'd3;

  // controller -> datapath, one-hot-ish action strobes per cycle
  typedef struct packed {
    logic load;       // capture transaction fields
    logic rd_node;    // read partial sum at node
    logic rd_probe;   // read partial sum at probe
    logic own_init;   // acc <= sum(node), probe <= 2*node
    logic own_sub;    // acc -= sum(probe), probe <= 2*probe+1
    logic add_chk;    // range check new weight, commit total
    logic up_wr;      // write back sum(node) + amount
    logic climb;      // node <= node/2
    logic sel_step;   // one level of the descent
    logic pick_load;  // node <= picked entry
    logic set_err;
    logic sw_start;
    logic sw_clear;   // sweep writes zero (no fill value)
    logic sw_cnt;
    logic sw_wr;
    logic sw_total;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       entry_bad;
    logic       tgt_bad;
    logic       fill_bad;
    logic       err;
    logic       probe_le_n;
    logic       node_le_n;
    logic       node_even;
    logic       node_one;
    logic       pick_zero;
    logic       sw_last;
  } stat_t;

endpackage

@@ hw/rtl/weighted_selection_tree.sv @@
`timescale 1ns / 1ps
// Sequence, accept to out_valid: query reads the entry's partial sum and subtracts the
//   sums of its left child and that child's right spine; select descends the levels, then
//   queries the picked entry; add queries, range-checks, then rewrites partial sums while
//   climbing; rejects end after dispatch (entry, target, fill) or after the check (add).
// Fill sweeps the memory, then sets the total. One transaction at a time, the next taken
//   while a result waits. Reset (sync, rst_n low), cfg write: in_stall high, memory zeroed.
module weighted_selection_tree #(
  parameter int TABLE_DEPTH = 4096,
  parameter int WEIGHT_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // request transaction
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_op,
  input  logic [12:0]        in_entry,
  input  logic signed [16:0] in_amount,
  input  logic [27:0]        in_target,
  // result transaction
  output logic               out_valid,
  input  logic               out_stall,
  output logic [12:0]        out_chosen_entry,
  output logic [15:0]        out_entry_weight,
  output logic [27:0]        out_total_weight,
  output logic               out_error,
  // entries-in-use register
  input  logic               cfg_wr_en,
  input  logic [12:0]        cfg_wr_data
);
  import wst_pkg::*;

  cmd_t  cmd;
  stat_t st;

  // sequencer: walks the tree one memory access at a time
  wst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_wr_en (cfg_wr_en),
    .st        (st),
    .cmd       (cmd)
  );

  // partial-sum memory, total, walk registers, result register
  wst_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_op            (in_op),
    .in_entry         (in_entry),
    .in_amount        (in_amount),
    .in_target        (in_target),
    .out_chosen_entry (out_chosen_entry),
    .out_entry_weight (out_entry_weight),
    .out_total_weight (out_total_weight),
    .out_error        (out_error)
  );

endmodule

@@ hw/rtl/wst_ctrl.sv @@
`timescale 1ns / 1ps
module wst_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  logic           cfg_wr_en,
  input  wst_pkg::stat_t st,
  output wst_pkg::cmd_t  cmd
);
  import wst_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_OW_RD  = 4'd2;
  localparam logic [3:0] S_OW_A   = 4'd3;
  localparam logic [3:0] S_OW_CHK = 4'd4;
  localparam logic [3:0] S_OW_SUB = 4'd5;
  localparam logic [3:0] S_ADD    = 4'd6;
  localparam logic [3:0] S_UP_RD  = 4'd7;
  localparam logic [3:0] S_UP_WR  = 4'd8;
  localparam logic [3:0] S_UP_ST  = 4'd9;
  localparam logic [3:0] S_SEL    = 4'd10;
  localparam logic [3:0] S_SELCHK = 4'd11;
  localparam logic [3:0] S_SW_A   = 4'd12;
  localparam logic [3:0] S_SW_B   = 4'd13;
  localparam logic [3:0] S_SW_END = 4'd14;
  localparam logic [3:0] S_FIN    = 4'd15;

  logic [3:0] state_r, state_nxt;
  logic       pend_r, pend_nxt;
  logic       clr_r, clr_nxt;
  logic       ov_r, ov_nxt;

  assign in_stall  = !(state_r == S_IDLE && !pend_r && !cfg_wr_en);
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r | cfg_wr_en;
    clr_nxt   = clr_r;
    ov_nxt    = ov_r && out_stall;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (pend_r) begin
          cmd.sw_start = 1'b1;
          cmd.sw_clear = 1'b1;
          pend_nxt     = cfg_wr_en;
          clr_nxt      = 1'b1;
          state_nxt    = S_SW_A;
        end else if (in_valid && !cfg_wr_en) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (st.op)
          OP_SELECT: begin
            if (st.tgt_bad) begin
              cmd.set_err = 1'b1;
              state_nxt   = S_FIN;
            end else begin
              cmd.rd_node = 1'b1;
              state_nxt   = S_SEL;
            end
          end
          OP_FILL: begin
            if (st.fill_bad) begin
              cmd.set_err = 1'b1;
              state_nxt   = S_FIN;
            end else begin
              cmd.sw_start = 1'b1;
              clr_nxt      = 1'b0;
              state_nxt    = S_SW_A;
            end
          end
          default: begin
            if (st.entry_bad) begin
              cmd.set_err = 1'b1;
              state_nxt   = S_FIN;
            end else begin
              state_nxt = S_OW_RD;
            end
          end
        endcase
      end
      S_OW_RD: begin
        cmd.rd_node = 1'b1;
        state_nxt   = S_OW_A;
      end
      S_OW_A: begin
        cmd.own_init = 1'b1;
        state_nxt    = S_OW_CHK;
      end
      S_OW_CHK: begin
        if (st.probe_le_n) begin
          cmd.rd_probe = 1'b1;
          state_nxt    = S_OW_SUB;
        end else if (st.op == OP_ADD) begin
          state_nxt = S_ADD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_OW_SUB: begin
        cmd.own_sub = 1'b1;
        state_nxt   = S_OW_CHK;
      end
      S_ADD: begin
        cmd.add_chk = 1'b1;
        state_nxt   = S_UP_RD;
      end
      S_UP_RD: begin
        if (st.err) begin
          state_nxt = S_FIN;
        end else begin
          cmd.rd_node = 1'b1;
          state_nxt   = S_UP_WR;
        end
      end
      S_UP_WR: begin
        cmd.up_wr = 1'b1;
        state_nxt = S_UP_ST;
      end
      S_UP_ST: begin
        if (st.node_one) begin
          state_nxt = S_FIN;
        end else begin
          cmd.climb = 1'b1;
          // parent takes the delta only when we come up from a left child
          if (st.node_even) begin
            cmd.rd_node = 1'b0;
            state_nxt   = S_UP_RD;
          end
        end
      end
      S_SEL: begin
        cmd.sel_step = 1'b1;
        state_nxt    = S_SELCHK;
      end
      S_SELCHK: begin
        if (st.node_le_n) begin
          cmd.rd_node = 1'b1;
          state_nxt   = S_SEL;
        end else if (st.pick_zero) begin
          cmd.set_err = 1'b1;
          state_nxt   = S_FIN;
        end else begin
          cmd.pick_load = 1'b1;
          state_nxt     = S_OW_RD;
        end
      end
      S_SW_A: begin
        cmd.sw_cnt = 1'b1;
        state_nxt  = S_SW_B;
      end
      S_SW_B: begin
        cmd.sw_wr = 1'b1;
        state_nxt = st.sw_last ? S_SW_END : S_SW_A;
      end
      S_SW_END: begin
        cmd.sw_total = 1'b1;
        state_nxt    = clr_r ? S_IDLE : S_FIN;
      end
      S_FIN: begin
        if (!ov_r || !out_stall) begin
          cmd.out_load = 1'b1;
          ov_nxt       = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= 1'b1;
      clr_r   <= 1'b1;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
    end
  end

endmodule

@@ hw/rtl/wst_dpath.sv @@
`timescale 1ns / 1ps
module wst_dpath #(
  parameter int TABLE_DEPTH = 4096,
  parameter int WEIGHT_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  wst_pkg::cmd_t      cmd,
  output wst_pkg::stat_t     st,
  input  logic               cfg_wr_en,
  input  logic [12:0]        cfg_wr_data,
  input  logic [1:0]         in_op,
  input  logic [12:0]        in_entry,
  input  logic signed [16:0] in_amount,
  input  logic [27:0]        in_target,
  output logic [12:0]        out_chosen_entry,
  output logic [15:0]        out_entry_weight,
  output logic [27:0]        out_total_weight,
  output logic               out_error
);
  import wst_pkg::*;

  localparam int WB    = WEIGHT_BITS;
  localparam int NW    = $clog2(TABLE_DEPTH + 1) + 1;
  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int SUM_W = (WB + NW > 28) ? (WB + NW) : 28;
  localparam int CW    = (NW > 13) ? NW : 13;
  localparam int BW    = ((SUM_W > 34) ? SUM_W : 34) + 1;
  localparam int DW    = 2 * NW;
  localparam logic [BW-1:0] WMAX = (BW'(1) << WB) - BW'(1);

  logic [SUM_W-1:0] mem [TABLE_DEPTH];
  logic [SUM_W-1:0] rd_r;

  logic [12:0]        cfg_r;
  logic [1:0]         op_r;
  logic [12:0]        entry_r;
  logic signed [16:0] amt_r;
  logic [SUM_W-1:0]   tgt_r, total_r, acc_r;
  logic [NW-1:0]      node_r, probe_r, pick_r, cnt_r;
  logic [WB-1:0]      fv_r;
  logic [12:0]        chosen_r;
  logic               err_r;

  logic [NW-1:0]      n_live;
  logic [CW-1:0]      cfg_x;
  logic [SUM_W-1:0]   amt_x;
  logic signed [BW-1:0] nw_s;
  logic               add_bad;
  logic [NW-1:0]      m_w;
  logic [DW-1:0]      m_x, n_x, sh_x, cnt_x, lvl_x, pw_x;
  logic               rd_en, wr_en;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic [SUM_W-1:0]   wr_data;

  // live entry count clamped to 1..TABLE_DEPTH
  always_comb begin
    cfg_x = CW'(cfg_r);
    if (cfg_r == 13'd0)                  n_live = NW'(1);
    else if (cfg_x > CW'(TABLE_DEPTH))   n_live = NW'(TABLE_DEPTH);
    else                                 n_live = NW'(cfg_x);
  end

  assign amt_x   = {{(SUM_W-17){amt_r[16]}}, amt_r};
  assign nw_s    = $signed({{(BW-SUM_W){1'b0}}, acc_r}) + BW'(amt_r);
  assign add_bad = nw_s[BW-1] || ($unsigned(nw_s) > WMAX);

  // node count of the left subtree of sweep node (root 2k) inside 1..n
  always_comb begin
    m_w   = {node_r[NW-2:0], 1'b0};
    m_x   = DW'(m_w);
    n_x   = DW'(n_live);
    sh_x  = m_x;
    pw_x  = DW'(1);
    for (int d = 0; d < NW; d++) begin
      if ((m_x << d) <= n_x) begin
        sh_x = m_x << d;
        pw_x = DW'(1) << d;
      end
    end
    lvl_x = n_x - sh_x + DW'(1);
    if (lvl_x > pw_x) lvl_x = pw_x;
    cnt_x = (m_x > n_x) ? DW'(0) : (pw_x - DW'(1) + lvl_x);
  end

  assign st.op         = op_r;
  assign st.entry_bad  = (entry_r == 13'd0) || (CW'(entry_r) > CW'(n_live));
  assign st.tgt_bad    = (tgt_r >= total_r);
  assign st.fill_bad   = amt_r[16] || (BW'(amt_r[15:0]) > WMAX);
  assign st.err        = err_r;
  assign st.probe_le_n = (probe_r <= n_live);
  assign st.node_le_n  = (node_r <= n_live);
  assign st.node_even  = !node_r[0];
  assign st.node_one   = (node_r == NW'(1));
  assign st.pick_zero  = (pick_r == '0);
  assign st.sw_last    = (node_r == NW'(TABLE_DEPTH));

  assign rd_en   = cmd.rd_node | cmd.rd_probe;
  assign rd_addr = cmd.rd_probe ? AW'(probe_r - NW'(1)) : AW'(node_r - NW'(1));
  assign wr_en   = cmd.up_wr | cmd.sw_wr;
  assign wr_addr = AW'(node_r - NW'(1));
  always_comb begin
    if (cmd.sw_wr) begin
      wr_data = (node_r <= n_live) ? SUM_W'(fv_r * (cnt_r + NW'(1))) : '0;
    end else begin
      wr_data = rd_r + amt_x;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_r <= mem[rd_addr];
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r   <= 13'(TABLE_DEPTH);
      total_r <= '0;
      err_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) cfg_r <= cfg_wr_data;
      if (cmd.load) err_r <= 1'b0;
      if (cmd.set_err || (cmd.add_chk && add_bad)) err_r <= 1'b1;
      if (cmd.add_chk && !add_bad) total_r <= total_r + amt_x;
      if (cmd.sw_total) total_r <= SUM_W'(fv_r * n_live);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_op;
      entry_r  <= in_entry;
      amt_r    <= in_amount;
      tgt_r    <= SUM_W'(in_target);
      acc_r    <= '0;
      pick_r   <= '0;
      chosen_r <= (in_op == OP_ADD || in_op == OP_QUERY) ? in_entry : 13'd0;
      node_r   <= (in_op == OP_SELECT) ? NW'(1) : NW'(in_entry);
    end
    if (cmd.own_init) begin
      acc_r   <= rd_r;
      probe_r <= {node_r[NW-2:0], 1'b0};
    end
    if (cmd.own_sub) begin
      acc_r   <= acc_r - rd_r;
      probe_r <= {probe_r[NW-2:0], 1'b1};
    end
    if (cmd.add_chk && !add_bad) acc_r <= SUM_W'($unsigned(nw_s));
    if (cmd.climb) node_r <= node_r >> 1;
    if (cmd.sel_step) begin
      if (tgt_r >= rd_r) begin
        tgt_r  <= tgt_r - rd_r;
        node_r <= {node_r[NW-2:0], 1'b1};
      end else begin
        pick_r <= node_r;
        node_r <= {node_r[NW-2:0], 1'b0};
      end
    end
    if (cmd.pick_load) begin
      node_r   <= pick_r;
      chosen_r <= 13'(pick_r);
    end
    if (cmd.sw_start) begin
      node_r <= NW'(1);
      fv_r   <= cmd.sw_clear ? '0 : WB'(amt_r[15:0]);
      if (!cmd.sw_clear) acc_r <= SUM_W'(amt_r[15:0]);
    end
    if (cmd.sw_cnt) cnt_r <= NW'(cnt_x);
    if (cmd.sw_wr) node_r <= node_r + NW'(1);
    if (cmd.out_load) begin
      out_chosen_entry <= chosen_r;
      out_entry_weight <= acc_r[15:0];
      out_total_weight <= total_r[27:0];
      out_error        <= err_r;
    end
  end

endmodule
